/* rtl/core/assert_macros.svh */
// assertion macros shared by the calendar core rtl
// no dependencies; compiled out when NO_ASSERTIONS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/mcg_pkg.sv */
// types, constants, month tables and microcode program of the calendar core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mcg_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COL_W   = 3;
  localparam int ROW_W   = 3;
  localparam int STAT_W  = 2;
  localparam int PROD_W  = 30;
  localparam int MULB_W  = 16;
  localparam int CUM_W   = 9;
  localparam int STEP_W  = 4;
  localparam int OP_W    = 4;
  localparam int JC_W    = 3;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [COL_W-1:0]   COL_MAX   = 3'd6;
  localparam logic [ROW_W-1:0]   ROW_MAX   = 3'd5;

  // floor(x/100) = (x*R100)>>19 and floor(x/7) = (x*R7)>>18 for x < 2**14
  localparam logic [MULB_W-1:0] R100     = 16'd5243;
  localparam int                R100_SH  = 19;
  localparam logic [MULB_W-1:0] R7       = 16'd37450;
  localparam int                R7_SH    = 18;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_YEAR  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_MONTH = 2'd2;

  localparam logic [OP_W-1:0] OP_NOP  = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
  localparam logic [OP_W-1:0] OP_MULY = 4'd2;
  localparam logic [OP_W-1:0] OP_MULN = 4'd3;
  localparam logic [OP_W-1:0] OP_LEAP = 4'd4;
  localparam logic [OP_W-1:0] OP_SUM  = 4'd5;
  localparam logic [OP_W-1:0] OP_MUL7 = 4'd6;
  localparam logic [OP_W-1:0] OP_MOD7 = 4'd7;
  localparam logic [OP_W-1:0] OP_STEP = 4'd8;

  localparam logic [JC_W-1:0] JC_NEVER     = 3'd0;
  localparam logic [JC_W-1:0] JC_ALWAYS    = 3'd1;
  localparam logic [JC_W-1:0] JC_IN_FIRE   = 3'd2;
  localparam logic [JC_W-1:0] JC_YEAR_BAD  = 3'd3;
  localparam logic [JC_W-1:0] JC_MONTH_BAD = 3'd4;
  localparam logic [JC_W-1:0] JC_OUT_FIRE  = 3'd5;
  localparam logic [JC_W-1:0] JC_LAST_FIRE = 3'd6;

  localparam logic [STEP_W-1:0] S_WAIT = 4'd0;
  localparam logic [STEP_W-1:0] S_CHKY = 4'd1;
  localparam logic [STEP_W-1:0] S_CHKM = 4'd2;
  localparam logic [STEP_W-1:0] S_LEAP = 4'd3;
  localparam logic [STEP_W-1:0] S_SUM  = 4'd4;
  localparam logic [STEP_W-1:0] S_MUL7 = 4'd5;
  localparam logic [STEP_W-1:0] S_MOD7 = 4'd6;
  localparam logic [STEP_W-1:0] S_EMIT = 4'd7;
  localparam logic [STEP_W-1:0] S_ERRY = 4'd8;
  localparam logic [STEP_W-1:0] S_ERRM = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              take_in;
    logic              emit;
    logic [STAT_W-1:0] status;
    logic [JC_W-1:0]   cond;
    logic              hold;
    logic [STEP_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic in_fire;
    logic out_fire;
  } hs_t;

  typedef struct packed {
    logic year_bad;
    logic month_bad;
    logic last_day;
  } dp_flags_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DAY_W-1:0]  day_number;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic              last;
  } cal_out_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // days in the months before m of a common year
  function automatic logic [CUM_W-1:0] month_cum(input logic [MONTH_W-1:0] m);
    logic [CUM_W-1:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic cw_t ucode(input logic [STEP_W-1:0] step);
    cw_t w;
    w = '{op: OP_NOP, take_in: 1'b0, emit: 1'b0, status: ST_OK,
          cond: JC_NEVER, hold: 1'b0, target: S_WAIT};
    unique case (step)
      S_WAIT: begin
        w.op = OP_LOAD; w.take_in = 1'b1;
        w.cond = JC_IN_FIRE; w.hold = 1'b1; w.target = S_CHKY;
      end
      S_CHKY: begin
        w.op = OP_MULY; w.cond = JC_YEAR_BAD; w.target = S_ERRY;
      end
      S_CHKM: begin
        w.op = OP_MULN; w.cond = JC_MONTH_BAD; w.target = S_ERRM;
      end
      S_LEAP: w.op = OP_LEAP;
      S_SUM:  w.op = OP_SUM;
      S_MUL7: w.op = OP_MUL7;
      S_MOD7: w.op = OP_MOD7;
      S_EMIT: begin
        w.op = OP_STEP; w.emit = 1'b1;
        w.cond = JC_LAST_FIRE; w.hold = 1'b1; w.target = S_WAIT;
      end
      S_ERRY: begin
        w.emit = 1'b1; w.status = ST_BAD_YEAR;
        w.cond = JC_OUT_FIRE; w.hold = 1'b1; w.target = S_WAIT;
      end
      S_ERRM: begin
        w.emit = 1'b1; w.status = ST_BAD_MONTH;
        w.cond = JC_OUT_FIRE; w.hold = 1'b1; w.target = S_WAIT;
      end
      default: begin
        w.cond = JC_ALWAYS; w.target = S_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mcg_if.sv */
// valid/ready channels of the calendar core: query in, day results out
// depends on mcg_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface mcg_query_if;
  logic                          valid;
  logic                          ready;
  logic [mcg_pkg::YEAR_W-1:0]    year;
  logic [mcg_pkg::MONTH_W-1:0]   month;

  modport source (output valid, output year, output month, input ready);
  modport sink (input valid, input year, input month, output ready);
endinterface

interface mcg_day_if;
  logic                          valid;
  logic                          ready;
  logic [mcg_pkg::STAT_W-1:0]    status;
  logic [mcg_pkg::DAY_W-1:0]     day_number;
  logic [mcg_pkg::COL_W-1:0]     column;
  logic [mcg_pkg::ROW_W-1:0]     row;
  logic                          last;

  modport source (output valid, output status, output day_number, output column,
                  output row, output last, input ready);
  modport sink (input valid, input status, input day_number, input column,
                input row, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/mcg_seq.sv */
// microcode sequencer: step counter, control rom and conditional jumps
// depends on mcg_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcg_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mcg_pkg::hs_t       hs,
  input  wire mcg_pkg::dp_flags_t flags,
  output mcg_pkg::cw_t            cw
);
  import mcg_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  logic              taken;

  assign cw = ucode(pc);

  always_comb begin
    unique case (cw.cond)
      JC_ALWAYS:    taken = 1'b1;
      JC_IN_FIRE:   taken = hs.in_fire;
      JC_YEAR_BAD:  taken = flags.year_bad;
      JC_MONTH_BAD: taken = flags.month_bad;
      JC_OUT_FIRE:  taken = hs.out_fire;
      JC_LAST_FIRE: taken = hs.out_fire && flags.last_day;
      default:      taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_next = cw.target;
    end else if (cw.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mcg_dp.sv */
// datapath: input latch, shared reciprocal multiplier, weekday sum, day walker
// depends on mcg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mcg_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mcg_pkg::cw_t                 cw,
  input  wire mcg_pkg::hs_t                 hs,
  input  wire logic [mcg_pkg::YEAR_W-1:0]   in_year,
  input  wire logic [mcg_pkg::MONTH_W-1:0]  in_month,
  output mcg_pkg::dp_flags_t                flags,
  output mcg_pkg::cal_out_t                 res
);
  import mcg_pkg::*;

  logic [YEAR_W-1:0]  y;
  logic [MONTH_W-1:0] m;
  logic [PROD_W-1:0]  prod;
  logic [6:0]         qy;
  logic [6:0]         qn;
  logic               leap;
  logic [YEAR_W-1:0]  sum;
  logic [DAY_W-1:0]   len;
  logic [DAY_W-1:0]   day;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;

  logic [YEAR_W-1:0]  n;
  logic [YEAR_W-1:0]  mul_a;
  logic [MULB_W-1:0]  mul_b;
  logic [YEAR_W-1:0]  qy100;
  logic [10:0]        q7;
  logic [YEAR_W-1:0]  q7x7;
  logic [YEAR_W-1:0]  rem7;
  logic [YEAR_W:0]    sum_w;
  logic               leap_adj;
  logic               ok;

  assign n     = y - YEAR_W'(1);
  assign qy100 = YEAR_W'({qy, 6'b0}) + YEAR_W'({qy, 5'b0}) + YEAR_W'({qy, 2'b0});
  assign q7    = prod[R7_SH +: 11];
  assign q7x7  = YEAR_W'({q7, 3'b0}) - YEAR_W'(q7);
  assign rem7  = sum - q7x7;
  assign leap_adj = leap && (m > MONTH_FEB);
  assign sum_w = (YEAR_W+1)'(n) + (YEAR_W+1)'(n[YEAR_W-1:2]) - (YEAR_W+1)'(qn)
               + (YEAR_W+1)'(qn[6:2]) + (YEAR_W+1)'(month_cum(m))
               + (YEAR_W+1)'(leap_adj);

  always_comb begin
    case (cw.op)
      OP_MULN: begin
        mul_a = n;
        mul_b = R100;
      end
      OP_MUL7: begin
        mul_a = sum;
        mul_b = R7;
      end
      default: begin
        mul_a = y;
        mul_b = R100;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (hs.in_fire) begin
          y <= in_year;
          m <= in_month;
        end
      end
      OP_MULY: prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      OP_MULN: begin
        qy   <= prod[R100_SH +: 7];
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      OP_LEAP: begin
        qn   <= prod[R100_SH +: 7];
        leap <= (y[1:0] == 2'b00) && ((y != qy100) || (qy[1:0] == 2'b00));
      end
      OP_SUM: begin
        sum <= sum_w[YEAR_W-1:0];
        len <= month_len(m) + DAY_W'((m == MONTH_FEB) && leap);
        day <= DAY_W'(1);
        row <= '0;
      end
      OP_MUL7: prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      OP_MOD7: col <= rem7[COL_W-1:0];
      OP_STEP: begin
        if (hs.out_fire && !flags.last_day) begin
          day <= day + DAY_W'(1);
          if (col == COL_MAX) begin
            col <= '0;
            row <= row + ROW_W'(1);
          end else begin
            col <= col + COL_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign flags.year_bad  = (y == '0) || (y > YEAR_MAX);
  assign flags.month_bad = (m == '0) || (m > MONTH_MAX);
  assign flags.last_day  = (day == len);

  assign ok             = (cw.status == ST_OK);
  assign res.status     = cw.status;
  assign res.day_number = ok ? day : '0;
  assign res.column     = ok ? col : '0;
  assign res.row        = ok ? row : '0;
  assign res.last       = ok ? flags.last_day : 1'b1;

  `ASSERT_IMP(a_day_range, clk, rst, cw.op == OP_STEP, (day != '0) && (day <= len))
  `ASSERT_IMP(a_grid_range, clk, rst, cw.op == OP_STEP, (col <= COL_MAX) && (row <= ROW_MAX))
  `ASSERT_NXT(a_day_advance, clk, rst, (cw.op == OP_STEP) && hs.out_fire && !flags.last_day, day == ($past(day) + DAY_W'(1)))

endmodule

`default_nettype wire

/* rtl/core/month_calendar_generator_core.sv */
// top level of the month calendar core: sequencer plus datapath
// depends on mcg_pkg, mcg_if, mcg_seq, mcg_dp
//
//   port    dir   payload                                   role
//   query   sink  year[13:0] month[3:0]                     one month to list
//   day     src   status day_number column row last         one item per day
//
// an item is set up in steps (latch, range checks, two divides by 100
// on the shared multiplier, weekday sum, divide by 7), then one day item
// leaves each time day takes one; an error item leaves after its range check
// the single shared multiplier and the step counter set this sequence
// rst is synchronous and returns the step counter to the wait step
// a stall on day holds the current item; query is not taken until the last one leaves
`timescale 1ns / 1ps
`default_nettype none

module month_calendar_generator_core (
  input  wire logic clk,
  input  wire logic rst,
  mcg_query_if.sink query,
  mcg_day_if.source day
);
  import mcg_pkg::*;

  cw_t       cw;
  hs_t       hs;
  dp_flags_t flags;
  cal_out_t  res;

  assign query.ready = cw.take_in;
  assign day.valid   = cw.emit;

  assign hs.in_fire  = query.valid && query.ready;
  assign hs.out_fire = day.valid && day.ready;

  mcg_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .hs    (hs),
    .flags (flags),
    .cw    (cw)
  );

  mcg_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cw       (cw),
    .hs       (hs),
    .in_year  (query.year),
    .in_month (query.month),
    .flags    (flags),
    .res      (res)
  );

  assign day.status     = res.status;
  assign day.day_number = res.day_number;
  assign day.column     = res.column;
  assign day.row        = res.row;
  assign day.last       = res.last;

endmodule

`default_nettype wire
